/* src/pgn_pkg.sv */
// Shared type, constants and helper functions for the NLL accumulator.
// Holds the log-factorial ROM; no dependencies.
`default_nettype none
package pgn_pkg;

  // ln(2) and ln(2 pi) in Q.32
  localparam logic [31:0]        LN2_Q32   = 32'd2977044472;
  localparam logic signed [63:0] LN2PI_Q32 = 64'sd7893621894;

  // sum clamp limits in Q32.16
  localparam logic signed [63:0] SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_MIN = -64'sh0000_8000_0000_0000;

  // saturated quotient value
  localparam logic [47:0] QUOT_CAP = 48'h8000_0000_0000;

  // dividend length of the serial divider
  localparam int unsigned DVD_BITS = 80;

  typedef logic signed [47:0] lf_tab_t [256];

  // round half away from zero, then shift right by s
  function automatic logic signed [65:0] round_sh(input logic signed [65:0] v,
                                                  input int unsigned s);
    logic [65:0] m;
    m = v[65] ? 66'(-v) : 66'(v);
    m = (m + (66'd1 << (s - 1))) >> s;
    return v[65] ? $signed(-m) : $signed(m);
  endfunction

  // natural log of a Q16.16 value in Q.32 (elaboration only)
  function automatic longint ln_q32_c(input longint unsigned v);
    longint unsigned x;
    longint unsigned frac;
    longint          l2;
    int              p;
    p    = 0;
    frac = 0;
    for (int i = 1; i < 32; i++) begin
      if ((v >> i) != 0) p = i;
    end
    x = (p <= 30) ? (v << (30 - p)) : (v >> (p - 30));
    for (int i = 0; i < 24; i++) begin
      x    = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd2 << 30)) begin
        x    = x >> 1;
        frac = frac | 64'd1;
      end
    end
    l2 = (longint'(p) - 16) * (64'sd1 << 24) + longint'(frac);
    return longint'(round_sh(66'(l2 * longint'(LN2_Q32)), 24));
  endfunction

  // ln(n!) in Q.32 for n = 0..255
  function automatic lf_tab_t build_lfact();
    lf_tab_t t;
    longint  acc;
    acc  = 0;
    t[0] = '0;
    t[1] = '0;
    for (int k = 2; k < 256; k++) begin
      acc  = acc + ln_q32_c(longint'(k) << 16);
      t[k] = 48'(acc);
    end
    return t;
  endfunction

  localparam lf_tab_t LFACT = build_lfact();

endpackage
`default_nettype wire

/* src/pgn_mul.sv */
// Shared signed 33x33 multiplier with a registered product.
// Depends on nothing.
`default_nettype none
module pgn_mul (
  input  wire logic               clk_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [32:0] b_i,
  output logic signed [65:0]      p_o
);

  logic signed [65:0] p_q;

  // one product per cycle
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

/* src/pgn_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle, saturating.
// Depends on pgn_pkg.
`default_nettype none
module pgn_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [79:0] dvd_i,
  input  wire logic [62:0] den_i,
  output logic             busy_o,
  output logic [47:0]      quo_o
);

  logic        busy_q;
  logic [6:0]  cnt_q;
  logic [79:0] dvd_q;
  logic [62:0] den_q;
  logic [62:0] rem_q;
  logic [47:0] q_q;
  logic        sat_q;
  logic [63:0] r2;
  logic        ge;

  // trial subtract
  assign r2 = {rem_q, dvd_q[79]};
  assign ge = r2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      q_q    <= '0;
      sat_q  <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      dvd_q  <= dvd_i;
      den_q  <= den_i;
      rem_q  <= '0;
      q_q    <= '0;
      sat_q  <= 1'b0;
    end else if (busy_q) begin
      rem_q  <= ge ? 63'(r2 - {1'b0, den_q}) : r2[62:0];
      q_q    <= {q_q[46:0], ge};
      sat_q  <= sat_q | q_q[46];
      dvd_q  <= {dvd_q[78:0], 1'b0};
      cnt_q  <= cnt_q + 7'd1;
      if (cnt_q == 7'(pgn_pkg::DVD_BITS - 1)) busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = sat_q ? pgn_pkg::QUOT_CAP : q_q;

endmodule
`default_nettype wire

/* src/poisson_gauss_nll_accumulator_core.sv */
// Top level: item sequencer for Poisson / Gaussian -2 ln L accumulation.
// Depends on pgn_pkg, pgn_mul, pgn_div.
//
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------
//  in      | in_valid_i / in_stall_o | kind, count, expected, value, center,
//          |                         | spread, last
//  out     | out_valid_o/out_stall_i | nll, infinite
//
// An item that adds nothing goes straight to the final step; a Poisson bin uses
// the log unit, a Gaussian bin or a constraint the log unit and the divider. The
// log unit (up to 31 normalize steps plus 24 squarings on the shared multiplier)
// and the 80-step serial divider set how long an item takes.
// Reset clears the sum, the infinite flag and the output register.
// A result waiting on out_stall_i holds only the final step of the next last item.
`default_nettype none
module poisson_gauss_nll_accumulator_core #(
  parameter int unsigned POISSON_LIMIT = 25
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [15:0] count_i,
  input  wire logic [31:0] expected_i,
  input  wire logic [31:0] value_i,
  input  wire logic [31:0] center_i,
  input  wire logic [31:0] spread_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [47:0]      nll_o,
  output logic             infinite_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_NORM, ST_SQ, ST_FIX, ST_SCL, ST_RND, ST_MLO, ST_MHI, ST_PSUM,
    ST_PRND, ST_DSQ, ST_SSQ, ST_DST, ST_DWT, ST_GSUM, ST_GRND, ST_ACC, ST_FIN
  } state_e;

  state_e             state_q;
  logic               kind_q, last_q, pois_q;
  logic [15:0]        n_q;
  logic [31:0]        mu_q, s_q, ad_q, v_q;
  logic [4:0]         p_q, cnt_q;
  logic [30:0]        x_q;
  logic [23:0]        frac_q;
  logic signed [39:0] ln_q;
  logic [63:0]        nl_q, sq_q;
  logic signed [63:0] t_q, term_q;
  logic signed [47:0] sum_q;
  logic               inf_q;
  logic               out_valid_q, out_inf_q;
  logic [47:0]        out_nll_q;

  logic               in_acc;
  logic signed [33:0] d_bin, d_con, d_sel;
  logic [33:0]        ad_abs;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic               div_start, div_busy;
  logic [79:0]        div_dvd;
  logic [62:0]        div_den;
  logic [47:0]        quo;
  logic [31:0]        xs;
  logic signed [65:0] nlx, tp, rnd_p, rnd_g, rnd_ln;
  logic signed [39:0] ln_mu;
  logic signed [63:0] ln64, sum64;
  logic signed [47:0] lf;
  logic               out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // |difference| of the squared-ratio term, formed at accept
  assign d_bin  = $signed({2'b00, count_i, 16'h0000}) - 34'(signed'(expected_i));
  assign d_con  = 34'(signed'(value_i)) - 34'(signed'(center_i));
  assign d_sel  = kind_i ? d_con : d_bin;
  assign ad_abs = d_sel[33] ? 34'(-d_sel) : 34'(d_sel);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQ: begin
        mul_a = {2'b00, x_q};
        mul_b = {2'b00, x_q};
      end
      ST_SCL: begin
        mul_a = 33'($signed({~p_q[4], p_q[3:0], frac_q}));
        mul_b = {1'b0, pgn_pkg::LN2_Q32};
      end
      ST_MLO: begin
        mul_a = {1'b0, ln_q[31:0]};
        mul_b = {17'h0, n_q};
      end
      ST_MHI: begin
        mul_a = 33'($signed(ln_q[39:32]));
        mul_b = {17'h0, n_q};
      end
      ST_DSQ: begin
        mul_a = {1'b0, ad_q};
        mul_b = {1'b0, ad_q};
      end
      ST_SSQ: begin
        mul_a = {1'b0, s_q};
        mul_b = {1'b0, s_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pgn_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // divider load
  assign div_start = (state_q == ST_DST);
  assign div_dvd   = kind_q ? {sq_q, 16'h0000} : {16'h0000, mul_p[63:0]};
  assign div_den   = kind_q ? mul_p[62:0] : {31'h0, mu_q};

  pgn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // datapath terms
  assign xs     = mul_p[61:30];
  assign rnd_ln = pgn_pkg::round_sh(mul_p, 24);
  assign ln_mu  = rnd_ln[39:0];
  assign lf     = pgn_pkg::LFACT[n_q[7:0]];
  assign nlx    = $signed({mul_p[33:0], 32'h0}) + $signed({2'b00, nl_q});
  assign tp     = 66'(lf) + $signed({{18{mu_q[31]}}, mu_q, 16'h0000}) - nlx;
  assign rnd_p  = pgn_pkg::round_sh({t_q[63], t_q, 1'b0}, 16);
  assign rnd_g  = pgn_pkg::round_sh(66'(t_q), 16);
  assign ln64   = 64'(ln_q);
  assign sum64  = 64'(sum_q) + term_q;

  // sequencer and registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= 1'b0;
      last_q      <= 1'b0;
      pois_q      <= 1'b0;
      n_q         <= '0;
      mu_q        <= '0;
      s_q         <= '0;
      ad_q        <= '0;
      v_q         <= '0;
      p_q         <= '0;
      cnt_q       <= '0;
      x_q         <= '0;
      frac_q      <= '0;
      ln_q        <= '0;
      nl_q        <= '0;
      sq_q        <= '0;
      t_q         <= '0;
      term_q      <= '0;
      sum_q       <= '0;
      inf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_inf_q   <= 1'b0;
      out_nll_q   <= '0;
    end else begin
      // result taken; a new one from the final step below takes its place
      if (out_valid_q && !out_stall_i && !(state_q == ST_FIN && last_q)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            kind_q <= kind_i;
            last_q <= last_i;
            n_q    <= count_i;
            mu_q   <= expected_i;
            s_q    <= spread_i;
            ad_q   <= ad_abs[31:0];
            v_q    <= kind_i ? spread_i : expected_i;
            p_q    <= 5'd31;
            pois_q <= !kind_i && (count_i <= 16'(POISSON_LIMIT));
            priority if (inf_q) begin
              state_q <= ST_FIN;
            end else if (!kind_i) begin
              if (expected_i[31] || expected_i == '0) begin
                if (count_i != '0) inf_q <= 1'b1;
                state_q <= ST_FIN;
              end else begin
                state_q <= ST_NORM;
              end
            end else begin
              if (spread_i[31] || spread_i == '0) begin
                inf_q   <= 1'b1;
                state_q <= ST_FIN;
              end else begin
                state_q <= ST_NORM;
              end
            end
          end
        end
        // shift until the top bit is set
        ST_NORM: begin
          if (v_q[31]) begin
            x_q     <= v_q[31:1];
            frac_q  <= '0;
            cnt_q   <= '0;
            state_q <= ST_SQ;
          end else begin
            v_q <= {v_q[30:0], 1'b0};
            p_q <= p_q - 5'd1;
          end
        end
        ST_SQ: state_q <= ST_FIX;
        // one fraction bit of log2 per squaring
        ST_FIX: begin
          if (xs[31]) begin
            x_q    <= xs[31:1];
            frac_q <= {frac_q[22:0], 1'b1};
          end else begin
            x_q    <= xs[30:0];
            frac_q <= {frac_q[22:0], 1'b0};
          end
          if (cnt_q == 5'd23) begin
            state_q <= ST_SCL;
          end else begin
            cnt_q   <= cnt_q + 5'd1;
            state_q <= ST_SQ;
          end
        end
        ST_SCL: state_q <= ST_RND;
        ST_RND: begin
          ln_q    <= ln_mu;
          state_q <= pois_q ? ST_MLO : ST_DSQ;
        end
        // Poisson: n * ln(mu) in two partial products
        ST_MLO: state_q <= ST_MHI;
        ST_MHI: begin
          nl_q    <= mul_p[63:0];
          state_q <= ST_PSUM;
        end
        ST_PSUM: begin
          t_q     <= tp[63:0];
          state_q <= ST_PRND;
        end
        ST_PRND: begin
          term_q  <= rnd_p[63:0];
          state_q <= ST_ACC;
        end
        // Gaussian: squared difference over variance, plus ln(2 pi) and ln(variance)
        ST_DSQ: state_q <= kind_q ? ST_SSQ : ST_DST;
        ST_SSQ: begin
          sq_q    <= mul_p[63:0];
          state_q <= ST_DST;
        end
        ST_DST: state_q <= ST_DWT;
        ST_DWT: begin
          if (!div_busy) state_q <= ST_GSUM;
        end
        ST_GSUM: begin
          t_q     <= pgn_pkg::LN2PI_Q32 + (kind_q ? (ln64 <<< 1) : ln64);
          state_q <= ST_GRND;
        end
        ST_GRND: begin
          term_q  <= rnd_g[63:0] + 64'(quo);
          state_q <= ST_ACC;
        end
        // saturating accumulate
        ST_ACC: begin
          priority if (sum64 > pgn_pkg::SUM_MAX) sum_q <= pgn_pkg::SUM_MAX[47:0];
          else if (sum64 < pgn_pkg::SUM_MIN)     sum_q <= pgn_pkg::SUM_MIN[47:0];
          else                                   sum_q <= sum64[47:0];
          state_q <= ST_FIN;
        end
        // emit on last, then clear
        ST_FIN: begin
          if (!last_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            out_inf_q   <= inf_q;
            out_nll_q   <= inf_q ? pgn_pkg::SUM_MAX[47:0] : sum_q;
            sum_q       <= '0;
            inf_q       <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign nll_o       = out_nll_q;
  assign infinite_o  = out_inf_q;

endmodule
`default_nettype wire

/* src/pgn_chk.sv */
// Port-level checker for the NLL accumulator, bound to the top level.
// Depends on pgn_pkg.
`default_nettype none
module pgn_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [47:0] nll_o,
  input wire logic        infinite_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(nll_o) && $stable(infinite_o))
    else $error("stalled result changed");

  // infinite result carries the largest sum
  a_inf_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && infinite_o |-> nll_o == pgn_pkg::SUM_MAX[47:0])
    else $error("infinite result without max sum");

  // an accepted item keeps the block busy next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("not busy after accept");

  // a new result comes out of an item in progress
  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without item in progress");

endmodule

bind poisson_gauss_nll_accumulator_core pgn_chk u_pgn_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .nll_o       (nll_o),
  .infinite_o  (infinite_o)
);
`default_nettype wire
